[design/ppr_pkg.sv]
// ---------------------------------------------------------------------------
// ppr_pkg
// Shared types, constants and tables of the planar pose regulator.
// ---------------------------------------------------------------------------
package ppr_pkg;

    localparam int CORDIC_STEPS = 16;          // 8..24
    localparam int CW           = 56;          // CORDIC x/y width

    localparam logic [31:0] MIN_TURN_RATE    = 32'd0;
    localparam logic [31:0] MIN_SPIN_RATE    = 32'd0;
    localparam logic [31:0] SPIN_SPEED_LIMIT = 32'd0;

    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'h9B74EDA8;
    localparam int          PI_Q16          = 205887;

    localparam logic [15:0] RST_TRANS_GAIN  = 16'd256;
    localparam logic [15:0] RST_ROT_GAIN    = 16'd256;
    localparam logic [15:0] RST_TRANS_TOL   = 16'd1311;
    localparam logic [15:0] RST_ROT_TOL     = 16'd2621;
    localparam logic [15:0] RST_SETTLE      = 16'd50;
    localparam logic [30:0] RST_MAX_LINEAR  = 31'd58982;
    localparam logic [30:0] RST_MAX_TURN    = 31'd91750;

    typedef enum logic [2:0] {
        REG_TRANS_GAIN  = 3'd0,
        REG_ROT_GAIN    = 3'd1,
        REG_TRANS_TOL   = 3'd2,
        REG_ROT_TOL     = 3'd3,
        REG_SETTLE      = 3'd4,
        REG_OMNI        = 3'd5,
        REG_MAX_LINEAR  = 3'd6,
        REG_MAX_TURN    = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_REACHED = 2'd1;
    localparam logic [1:0] STATUS_STALE   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT_INIT,
        OP_VEC_INIT,
        OP_CORDIC,
        OP_GABS,
        OP_GLO,
        OP_GHI,
        OP_GRND,
        OP_YAW,
        OP_YRAD,
        OP_TOL,
        OP_VEL,
        OP_SHIFT,
        OP_SQA,
        OP_SQB,
        OP_SQL,
        OP_CMP,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_SQRT_END,
        OP_MUL,
        OP_DIV,
        OP_QSTORE,
        OP_FINAL,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic       sel;     // 0: x component, 1: y component
    } dp_cmd_t;

    typedef struct packed {
        logic need_bearing;
        logic big;
        logic limited;
        logic reached;
        logic out_full;
    } dp_stat_t;

    // arctangent of 2^-i, 2^31 = pi
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[design/ppr_in_if.sv]
// ---------------------------------------------------------------------------
// ppr_in_if
// Pose channel: target and robot pose of one control tick.
// ---------------------------------------------------------------------------
interface ppr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] pos_heading;
    logic               pose_stale;
    logic               new_goal;

    modport source (
        output valid, goal_x, goal_y, goal_heading, pos_x, pos_y, pos_heading,
               pose_stale, new_goal,
        input  ready
    );
    modport sink (
        input  valid, goal_x, goal_y, goal_heading, pos_x, pos_y, pos_heading,
               pose_stale, new_goal,
        output ready
    );
endinterface

[design/ppr_out_if.sv]
// ---------------------------------------------------------------------------
// ppr_out_if
// Command channel: velocity command and status of one control tick.
// ---------------------------------------------------------------------------
interface ppr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cmd_vx;
    logic signed [31:0] cmd_vy;
    logic signed [31:0] cmd_wz;
    logic        [1:0]  status;

    modport source (
        output valid, cmd_vx, cmd_vy, cmd_wz, status,
        input  ready
    );
    modport sink (
        input  valid, cmd_vx, cmd_vy, cmd_wz, status,
        output ready
    );
endinterface

[design/planar_pose_regulator.sv]
// ---------------------------------------------------------------------------
// planar_pose_regulator
// Proportional pose controller with norm and turn-rate limits and a settle
// counter, one command transaction per pose transaction.
// ---------------------------------------------------------------------------
//  port       dir  payload
//  pose       in   goal_x/y/heading, pos_x/y/heading, pose_stale, new_goal
//  command    out  cmd_vx, cmd_vy, cmd_wz, status
//  cfg_*      in   write enable, 3 bit register index, 31 bit data
//
//  One pose transaction at a time. A stale pose goes straight to the write
//  state and a reached goal skips the velocity, limit and final steps; the
//  bearing CORDIC runs when needed; a 32-step square root and two 32-step
//  dividers, after any shift steps, run when the linear vector is limited.
//  The CORDIC steps, the square root and the restoring divider set the latency.
//  Reset clears the sequencer, settle counter and config to defaults.
//  A finished command waits in the output register; pose is taken again
//  right away and only the next write stalls on command.ready.
// ---------------------------------------------------------------------------
module planar_pose_regulator (
    input  logic        clk,
    input  logic        rst_n,
    ppr_in_if.sink      pose,
    ppr_out_if.source   command,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    ppr_pkg::dp_cmd_t  dp_cmd;
    ppr_pkg::dp_stat_t dp_stat;
    logic              in_ready;

    assign pose.ready = in_ready;

    // sequencer
    ppr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pose.valid),
        .in_stale  (pose.pose_stale),
        .in_ready  (in_ready),
        .out_ready (command.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // arithmetic, settle counter, config and output register
    ppr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .goal_x       (pose.goal_x),
        .goal_y       (pose.goal_y),
        .goal_heading (pose.goal_heading),
        .pos_x        (pose.pos_x),
        .pos_y        (pose.pos_y),
        .pos_heading  (pose.pos_heading),
        .pose_stale   (pose.pose_stale),
        .new_goal     (pose.new_goal),
        .out_ready    (command.ready),
        .out_valid    (command.valid),
        .cmd_vx       (command.cmd_vx),
        .cmd_vy       (command.cmd_vy),
        .cmd_wz       (command.cmd_wz),
        .status       (command.status)
    );

endmodule

[design/ppr_ctrl.sv]
// ---------------------------------------------------------------------------
// ppr_ctrl
// Sequencer: steps the datapath through one control tick.
// ---------------------------------------------------------------------------
module ppr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stale,
    output logic              in_ready,
    input  logic              out_ready,
    input  ppr_pkg::dp_stat_t stat,
    output ppr_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_ROT_INIT, S_ROT, S_GABS, S_GLO, S_GHI, S_GRND, S_DECIDE,
        S_VEC_INIT, S_VEC, S_YAW, S_YRAD, S_TOL, S_VEL, S_SHIFT, S_SQA, S_SQB,
        S_SQL, S_CMP, S_LIMCHK, S_SQRT_INIT, S_SQRT, S_SQRT_END, S_MUL, S_DIV,
        S_QSTORE, S_FINAL, S_WRITE
    } state_t;

    localparam logic [4:0] LAST_CORDIC = 5'(ppr_pkg::CORDIC_STEPS - 1);
    localparam logic [4:0] LAST_ITER   = 5'd31;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       sel_reg, sel_next;
    ppr_pkg::dp_op_t op;

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.op   = op;
    assign cmd.step = step_reg;
    assign cmd.sel  = sel_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        op         = ppr_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = ppr_pkg::OP_LOAD;
                    state_next = in_stale ? S_WRITE : S_ROT_INIT;
                end
            end
            S_ROT_INIT:
            begin
                op         = ppr_pkg::OP_ROT_INIT;
                step_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                op        = ppr_pkg::OP_CORDIC;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_CORDIC)
                begin
                    sel_next   = 1'b0;
                    state_next = S_GABS;
                end
            end
            S_GABS:
            begin
                op         = ppr_pkg::OP_GABS;
                state_next = S_GLO;
            end
            S_GLO:
            begin
                op         = ppr_pkg::OP_GLO;
                state_next = S_GHI;
            end
            S_GHI:
            begin
                op         = ppr_pkg::OP_GHI;
                state_next = S_GRND;
            end
            S_GRND:
            begin
                op         = ppr_pkg::OP_GRND;
                sel_next   = 1'b1;
                state_next = sel_reg ? S_DECIDE : S_GABS;
            end
            S_DECIDE:
            begin
                state_next = stat.need_bearing ? S_VEC_INIT : S_YAW;
            end
            S_VEC_INIT:
            begin
                op         = ppr_pkg::OP_VEC_INIT;
                step_next  = '0;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                op        = ppr_pkg::OP_CORDIC;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_CORDIC)
                    state_next = S_YAW;
            end
            S_YAW:
            begin
                op         = ppr_pkg::OP_YAW;
                state_next = S_YRAD;
            end
            S_YRAD:
            begin
                op         = ppr_pkg::OP_YRAD;
                state_next = S_TOL;
            end
            S_TOL:
            begin
                op         = ppr_pkg::OP_TOL;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                if (stat.reached)
                    state_next = S_WRITE;
                else
                begin
                    op         = ppr_pkg::OP_VEL;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.big)
                    op = ppr_pkg::OP_SHIFT;
                else
                    state_next = S_SQA;
            end
            S_SQA:
            begin
                op         = ppr_pkg::OP_SQA;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                op         = ppr_pkg::OP_SQB;
                state_next = S_SQL;
            end
            S_SQL:
            begin
                op         = ppr_pkg::OP_SQL;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                op         = ppr_pkg::OP_CMP;
                state_next = S_LIMCHK;
            end
            S_LIMCHK:
            begin
                state_next = stat.limited ? S_SQRT_INIT : S_FINAL;
            end
            S_SQRT_INIT:
            begin
                op         = ppr_pkg::OP_SQRT_INIT;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op        = ppr_pkg::OP_SQRT;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_ITER)
                    state_next = S_SQRT_END;
            end
            S_SQRT_END:
            begin
                op         = ppr_pkg::OP_SQRT_END;
                sel_next   = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                op         = ppr_pkg::OP_MUL;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op        = ppr_pkg::OP_DIV;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_ITER)
                    state_next = S_QSTORE;
            end
            S_QSTORE:
            begin
                op         = ppr_pkg::OP_QSTORE;
                sel_next   = 1'b1;
                state_next = sel_reg ? S_FINAL : S_MUL;
            end
            S_FINAL:
            begin
                op         = ppr_pkg::OP_FINAL;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!stat.out_full || out_ready)
                begin
                    op         = ppr_pkg::OP_WRITE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

[design/ppr_dp.sv]
// ---------------------------------------------------------------------------
// ppr_dp
// Datapath: config registers, shared CORDIC, gain multiplier, square root,
// divider, settle counter and the command output register.
// ---------------------------------------------------------------------------
module ppr_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ppr_pkg::dp_cmd_t   cmd,
    output ppr_pkg::dp_stat_t  stat,
    // configuration
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    // pose fields
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [15:0] goal_heading,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] pos_heading,
    input  logic               pose_stale,
    input  logic               new_goal,
    // command output register
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [31:0] cmd_vx,
    output logic signed [31:0] cmd_vy,
    output logic signed [31:0] cmd_wz,
    output logic [1:0]         status
);

    localparam int CW = ppr_pkg::CW;

    function automatic logic [35:0] mag36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    function automatic logic [44:0] mag45(input logic signed [44:0] v);
        return v[44] ? 45'(-v) : 45'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] apply_min(input logic signed [31:0] w,
                                                    input logic [31:0] lim);
        logic signed [31:0] r;
        r = w;
        if (mag32(w) < lim)
            r = w[31] ? -$signed(lim) : $signed(lim);
        return r;
    endfunction

    // configuration registers
    logic [15:0] trans_gain_reg, rot_gain_reg, trans_tol_reg, rot_tol_reg, settle_ticks_reg;
    logic        omni_reg;
    logic [30:0] max_lin_reg, max_turn_reg;

    // latched pose
    logic signed [31:0] gx_reg, gy_reg, px_reg, py_reg;
    logic signed [15:0] gh_reg, ph_reg;
    logic               stale_reg;

    logic [15:0]          settle_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0]          cz_reg;
    logic                 vec_mode_reg, bear_reg, zero_reg;
    logic [CW-1:0]        gm_reg, acc_reg;
    logic                 gs_reg;
    logic signed [35:0]   ex_reg, ey_reg;
    logic signed [15:0]   yaw_reg;
    logic signed [19:0]   yrad_reg;
    logic                 reached_reg;
    logic signed [44:0]   vx_reg, vy_reg;
    logic signed [31:0]   wz_reg;
    logic [44:0]          a_reg, b_reg;
    logic                 shifted_reg, limited_reg;
    logic [61:0]          sq_reg, lsq_reg;
    logic [62:0]          sum_reg, sv_reg, sr_reg, sbit_reg;
    logic [31:0]          n_reg, rem_reg, low_reg;
    logic [30:0]          qx_reg, qy_reg;
    logic signed [31:0]   fvx_reg, fvy_reg, fwz_reg;

    // ---- combinational helpers ----
    logic signed [32:0]   dx33, dy33;
    logic signed [CW-1:0] rx0, ry0, vx0, vy0, csrc, cdx, cdy;
    logic [31:0]          rz0, atan_v;
    logic                 cdir;
    logic [63:0]          plo;
    logic [55:0]          phi;
    logic signed [56:0]   gt;
    logic signed [56:0]   gu;
    logic [35:0]          exm, eym, yradm;
    logic [31:0]          bz, bsum;
    logic signed [15:0]   fwd, rev, yaw_sel;
    logic signed [35:0]   yprod;
    logic                 in_tol;
    logic [15:0]          cnt_inc;
    logic signed [52:0]   vxp, vyp;
    logic signed [36:0]   wzp;
    logic signed [44:0]   vxn, vyn;
    logic [62:0]          st;
    logic [61:0]          dprod;
    logic [32:0]          dt;
    logic signed [31:0]   fx, fy, w1, w2;
    logic [31:0]          wzm;

    always_comb
    begin
        dx33 = 33'(gx_reg) - 33'(px_reg);
        dy33 = 33'(gy_reg) - 33'(py_reg);
        rx0  = {{(CW-49){dx33[32]}}, dx33, 16'h0};
        ry0  = {{(CW-49){dy33[32]}}, dy33, 16'h0};
        rz0  = 32'h0 - {ph_reg, 16'h0};
        vx0  = {{(CW-52){ex_reg[35]}}, ex_reg, 16'h0};
        vy0  = {{(CW-52){ey_reg[35]}}, ey_reg, 16'h0};

        atan_v = ppr_pkg::atan_entry(cmd.step);
        cdx    = cy_reg >>> cmd.step;
        cdy    = cx_reg >>> cmd.step;
        cdir   = vec_mode_reg ? !cy_reg[CW-1] : cz_reg[31];

        csrc = cmd.sel ? cy_reg : cx_reg;
        plo  = 64'(gm_reg[31:0]) * 64'(ppr_pkg::CORDIC_GAIN_Q32);
        phi  = 56'(gm_reg[CW-1:32]) * 56'(ppr_pkg::CORDIC_GAIN_Q32);
        gt   = gs_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        gu   = (gt + 57'sd32768) >>> 16;

        exm   = mag36(ex_reg);
        eym   = mag36(ey_reg);
        yradm = mag36(36'(yrad_reg));

        bz      = zero_reg ? 32'h0 : cz_reg;
        bsum    = bz + 32'h8000;
        fwd     = $signed(bsum[31:16]);
        rev     = {~fwd[15], fwd[14:0]};
        yaw_sel = gh_reg - ph_reg;
        if (bear_reg)
            yaw_sel = (mag32(32'(rev)) < mag32(32'(fwd))) ? rev : fwd;
        yprod = 36'(yaw_reg) * 36'(ppr_pkg::PI_Q16);

        in_tol  = (exm <= 36'(trans_tol_reg)) && (eym <= 36'(trans_tol_reg))
                  && (yradm <= 36'(rot_tol_reg));
        cnt_inc = (settle_reg == 16'hFFFF) ? settle_reg : settle_reg + 16'd1;

        vxp = 53'(ex_reg) * $signed({37'b0, trans_gain_reg});
        vyp = 53'(ey_reg) * $signed({37'b0, trans_gain_reg});
        wzp = 37'(yrad_reg) * $signed({21'b0, rot_gain_reg});
        vxn = 45'((vxp + 53'sd128) >>> 8);
        vyn = omni_reg ? 45'((vyp + 53'sd128) >>> 8) : 45'sd0;

        st    = sr_reg + sbit_reg;
        dprod = 62'(cmd.sel ? b_reg[30:0] : a_reg[30:0]) * 62'(max_lin_reg);
        dt    = {rem_reg, low_reg[31]};

        fx = limited_reg ? (vx_reg[44] ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg}))
                         : 32'(vx_reg);
        fy = limited_reg ? (vy_reg[44] ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg}))
                         : 32'(vy_reg);
        wzm = mag32(wz_reg);
        w1  = wz_reg;
        if (wzm > 32'(max_turn_reg))
            w1 = wz_reg[31] ? -$signed({1'b0, max_turn_reg}) : $signed({1'b0, max_turn_reg});
        w2 = apply_min(w1, ppr_pkg::MIN_TURN_RATE);
        if (mag32(fx) < ppr_pkg::SPIN_SPEED_LIMIT && mag32(fy) < ppr_pkg::SPIN_SPEED_LIMIT)
            w2 = apply_min(w2, ppr_pkg::MIN_SPIN_RATE);
    end

    assign stat.need_bearing = !omni_reg && ((exm > 36'(trans_tol_reg))
                                             || (eym > 36'(trans_tol_reg)));
    assign stat.big      = (|a_reg[44:31]) || (|b_reg[44:31]);
    assign stat.limited  = limited_reg;
    assign stat.reached  = reached_reg;
    assign stat.out_full = out_valid;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_gain_reg   <= ppr_pkg::RST_TRANS_GAIN;
            rot_gain_reg     <= ppr_pkg::RST_ROT_GAIN;
            trans_tol_reg    <= ppr_pkg::RST_TRANS_TOL;
            rot_tol_reg      <= ppr_pkg::RST_ROT_TOL;
            settle_ticks_reg <= ppr_pkg::RST_SETTLE;
            omni_reg         <= 1'b1;
            max_lin_reg      <= ppr_pkg::RST_MAX_LINEAR;
            max_turn_reg     <= ppr_pkg::RST_MAX_TURN;
        end
        else if (cfg_write)
        begin
            unique case (ppr_pkg::cfg_reg_t'(cfg_index))
                ppr_pkg::REG_TRANS_GAIN: trans_gain_reg   <= cfg_data[15:0];
                ppr_pkg::REG_ROT_GAIN:   rot_gain_reg     <= cfg_data[15:0];
                ppr_pkg::REG_TRANS_TOL:  trans_tol_reg    <= cfg_data[15:0];
                ppr_pkg::REG_ROT_TOL:    rot_tol_reg      <= cfg_data[15:0];
                ppr_pkg::REG_SETTLE:     settle_ticks_reg <= cfg_data[15:0];
                ppr_pkg::REG_OMNI:       omni_reg         <= cfg_data[0];
                ppr_pkg::REG_MAX_LINEAR: max_lin_reg      <= cfg_data;
                ppr_pkg::REG_MAX_TURN:   max_turn_reg     <= cfg_data;
                default:                 omni_reg         <= omni_reg;
            endcase
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg  <= '0;
            stale_reg   <= 1'b0;
            reached_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cmd.op == ppr_pkg::OP_LOAD)
            begin
                stale_reg   <= pose_stale;
                reached_reg <= 1'b0;
                if (new_goal || pose_stale)
                    settle_reg <= '0;
            end
            if (cmd.op == ppr_pkg::OP_TOL)
            begin
                settle_reg  <= in_tol ? cnt_inc : 16'd0;
                reached_reg <= in_tol && (cnt_inc >= settle_ticks_reg);
            end
            if (cmd.op == ppr_pkg::OP_WRITE)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ppr_pkg::OP_LOAD:
            begin
                gx_reg <= goal_x;
                gy_reg <= goal_y;
                gh_reg <= goal_heading;
                px_reg <= pos_x;
                py_reg <= pos_y;
                ph_reg <= pos_heading;
                bear_reg <= 1'b0;
            end
            ppr_pkg::OP_ROT_INIT:
            begin
                vec_mode_reg <= 1'b0;
                if (((rz0 + 32'h40000000) & 32'h80000000) != 32'h0)
                begin
                    cx_reg <= -rx0;
                    cy_reg <= -ry0;
                    cz_reg <= rz0 + 32'h80000000;
                end
                else
                begin
                    cx_reg <= rx0;
                    cy_reg <= ry0;
                    cz_reg <= rz0;
                end
            end
            ppr_pkg::OP_VEC_INIT:
            begin
                vec_mode_reg <= 1'b1;
                bear_reg     <= 1'b1;
                zero_reg     <= (ex_reg == 36'sd0) && (ey_reg == 36'sd0);
                if (ex_reg[35])
                begin
                    cx_reg <= -vx0;
                    cy_reg <= -vy0;
                    cz_reg <= 32'h80000000;
                end
                else
                begin
                    cx_reg <= vx0;
                    cy_reg <= vy0;
                    cz_reg <= 32'h0;
                end
            end
            ppr_pkg::OP_CORDIC:
            begin
                if (cdir)
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            ppr_pkg::OP_GABS:
            begin
                gs_reg <= csrc[CW-1];
                gm_reg <= csrc[CW-1] ? CW'(-csrc) : CW'(csrc);
            end
            ppr_pkg::OP_GLO: acc_reg <= CW'(plo[63:32]);
            ppr_pkg::OP_GHI: acc_reg <= acc_reg + phi;
            ppr_pkg::OP_GRND:
            begin
                if (cmd.sel)
                    ey_reg <= 36'(gu);
                else
                    ex_reg <= 36'(gu);
            end
            ppr_pkg::OP_YAW:  yaw_reg  <= yaw_sel;
            ppr_pkg::OP_YRAD: yrad_reg <= 20'((yprod + 36'sd16384) >>> 15);
            ppr_pkg::OP_VEL:
            begin
                vx_reg      <= vxn;
                vy_reg      <= vyn;
                wz_reg      <= 32'((wzp + 37'sd128) >>> 8);
                a_reg       <= mag45(vxn);
                b_reg       <= mag45(vyn);
                shifted_reg <= 1'b0;
            end
            ppr_pkg::OP_SHIFT:
            begin
                a_reg       <= a_reg >> 1;
                b_reg       <= b_reg >> 1;
                shifted_reg <= 1'b1;
            end
            ppr_pkg::OP_SQA: sq_reg  <= 62'(a_reg[30:0]) * 62'(a_reg[30:0]);
            ppr_pkg::OP_SQB: sum_reg <= 63'(sq_reg) + 63'(62'(b_reg[30:0]) * 62'(b_reg[30:0]));
            ppr_pkg::OP_SQL: lsq_reg <= 62'(max_lin_reg) * 62'(max_lin_reg);
            ppr_pkg::OP_CMP: limited_reg <= shifted_reg || (sum_reg > 63'(lsq_reg));
            ppr_pkg::OP_SQRT_INIT:
            begin
                sv_reg   <= sum_reg;
                sr_reg   <= '0;
                sbit_reg <= {1'b1, 62'b0};
            end
            ppr_pkg::OP_SQRT:
            begin
                if (sv_reg >= st)
                begin
                    sv_reg <= sv_reg - st;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
            end
            ppr_pkg::OP_SQRT_END:
                n_reg <= (sv_reg != 63'd0) ? 32'(sr_reg) + 32'd1 : 32'(sr_reg);
            ppr_pkg::OP_MUL:
            begin
                rem_reg <= {2'b0, dprod[61:32]};
                low_reg <= dprod[31:0];
            end
            ppr_pkg::OP_DIV:
            begin
                if (dt >= {1'b0, n_reg})
                begin
                    rem_reg <= 32'(dt - {1'b0, n_reg});
                    low_reg <= {low_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dt[31:0];
                    low_reg <= {low_reg[30:0], 1'b0};
                end
            end
            ppr_pkg::OP_QSTORE:
            begin
                if (cmd.sel)
                    qy_reg <= low_reg[30:0];
                else
                    qx_reg <= low_reg[30:0];
            end
            ppr_pkg::OP_FINAL:
            begin
                fvx_reg <= fx;
                fvy_reg <= fy;
                fwz_reg <= w2;
            end
            ppr_pkg::OP_WRITE:
            begin
                if (stale_reg || reached_reg)
                begin
                    cmd_vx <= '0;
                    cmd_vy <= '0;
                    cmd_wz <= '0;
                end
                else
                begin
                    cmd_vx <= fvx_reg;
                    cmd_vy <= fvy_reg;
                    cmd_wz <= fwz_reg;
                end
                status <= stale_reg   ? ppr_pkg::STATUS_STALE :
                          reached_reg ? ppr_pkg::STATUS_REACHED : ppr_pkg::STATUS_RUNNING;
            end
            default:
            begin
            end
        endcase
    end

    // a result is only written into a free or draining output register
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == ppr_pkg::OP_WRITE |-> (!out_valid || out_ready))
        else $error("result written over an unread command");

    // stale and reached transactions carry a zero command
    a_zero_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ppr_pkg::STATUS_RUNNING)
            |-> (cmd_vx == 32'sd0 && cmd_vy == 32'sd0 && cmd_wz == 32'sd0))
        else $error("nonzero command with stop status");

    // status code is always a defined one
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ppr_pkg::STATUS_RUNNING || status == ppr_pkg::STATUS_REACHED
                       || status == ppr_pkg::STATUS_STALE))
        else $error("undefined status code");

endmodule
